// File: design/lifo_stack_with_search_macros.svh
// assertion macros shared by the lifo stack with search design
`ifndef LIFO_STACK_WITH_SEARCH_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define LSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lss assertion failed");

// next-cycle implication
`define LSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lss assertion failed");

`endif

// File: design/lss_pkg.sv
// types and constants of the lifo stack with search
`timescale 1ns / 1ps

package lss_pkg;

    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 3;
    localparam int POS_W  = 5;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int STEP_W = $clog2(DEPTH);

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH   = 3'd0,
        CMD_POP    = 3'd1,
        CMD_CLEAR  = 3'd2,
        CMD_SEARCH = 3'd3,
        CMD_READ   = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK      = 3'd0,
        STAT_EMPTY   = 3'd1,
        STAT_FULL    = 3'd2,
        STAT_RANGE   = 3'd3,
        STAT_NOMATCH = 3'd4
    } t_status;

    // hold, take the word from the neighbor nearer the top, or from the one below
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_DOWN,
        CELL_SHIFT_UP
    } t_cell_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } t_state;

endpackage

// File: design/lss_cell.sv
// one storage cell of the stack chain
`timescale 1ns / 1ps

module lss_cell (
    input  logic                       i_clk,
    input  lss_pkg::t_cell_op          i_op,
    input  logic [lss_pkg::DATA_W-1:0] i_from_up,
    input  logic [lss_pkg::DATA_W-1:0] i_from_down,
    output logic [lss_pkg::DATA_W-1:0] o_data
);

    logic [lss_pkg::DATA_W-1:0] r_data;
    logic [lss_pkg::DATA_W-1:0] n_data;

    always_comb begin
        case (i_op)
            lss_pkg::CELL_SHIFT_DOWN: n_data = i_from_up;
            lss_pkg::CELL_SHIFT_UP:   n_data = i_from_down;
            default:                  n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: design/lifo_stack_with_search.sv
// Push, pop, clear, an out-of-range read and unknown codes: result strobe in the cycle
// after the request, busy stays low, so one request per cycle.
// Search and in-range read rotate the cell chain once round in the scan state; search then
// adds a finish state for the final result; busy stays high in the scan and finish states.
// Results are strobed for one cycle each; the receiver cannot stall them.
// Synchronous active-low reset empties the stack; cell contents are undefined until pushed.
`timescale 1ns / 1ps

module lifo_stack_with_search (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [lss_pkg::CMD_W-1:0]  i_cmd,
    input  logic [lss_pkg::DATA_W-1:0] i_value,
    input  logic [lss_pkg::POS_W-1:0]  i_position,
    output logic                       o_busy,
    output logic                       o_valid,
    output logic [lss_pkg::STAT_W-1:0] o_status,
    output logic [lss_pkg::POS_W-1:0]  o_found_position,
    output logic [lss_pkg::DATA_W-1:0] o_data,
    output logic [lss_pkg::POS_W-1:0]  o_fill_count,
    output logic                       o_last
);

`include "lifo_stack_with_search_macros.svh"

    lss_pkg::t_state             r_state, n_state;
    logic [lss_pkg::CNT_W-1:0]   r_occ, n_occ;
    logic [lss_pkg::STEP_W-1:0]  r_step, n_step;
    logic                        r_is_read, n_is_read;
    logic [lss_pkg::DATA_W-1:0]  r_key, n_key;
    logic [lss_pkg::POS_W-1:0]   r_pos, n_pos;
    logic                        r_pend_vld, n_pend_vld;
    logic [lss_pkg::POS_W-1:0]   r_pend_pos, n_pend_pos;
    logic [lss_pkg::DATA_W-1:0]  r_pend_data, n_pend_data;
    logic                        r_valid, n_valid;
    lss_pkg::t_status            r_status, n_status;
    logic [lss_pkg::POS_W-1:0]   r_fpos, n_fpos;
    logic [lss_pkg::DATA_W-1:0]  r_odata, n_odata;
    logic [lss_pkg::POS_W-1:0]   r_fill, n_fill;
    logic                        r_last, n_last;

    lss_pkg::t_cell_op           w_op;
    logic [lss_pkg::DATA_W-1:0]  w_cell [lss_pkg::DEPTH];
    logic [lss_pkg::POS_W-1:0]   w_cur_pos;
    logic                        w_accept;

    // cell 0 is the top; rotating up walks every entry past it and wraps back
    for (genvar k = 0; k < lss_pkg::DEPTH; k++) begin : g_cell
        logic [lss_pkg::DATA_W-1:0] w_up;
        logic [lss_pkg::DATA_W-1:0] w_down;
        if (k == 0) begin : g_top
            assign w_up = i_value;
        end else begin : g_mid_up
            assign w_up = w_cell[k-1];
        end
        if (k == lss_pkg::DEPTH - 1) begin : g_bottom
            assign w_down = w_cell[0];
        end else begin : g_mid_down
            assign w_down = w_cell[k+1];
        end
        lss_cell u_cell (
            .i_clk       (i_clk),
            .i_op        (w_op),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_data      (w_cell[k])
        );
    end

    assign w_accept  = i_start && (r_state == lss_pkg::ST_IDLE);
    assign w_cur_pos = lss_pkg::POS_W'(r_step) + lss_pkg::POS_W'(1);

    always_comb begin
        n_state     = r_state;
        n_occ       = r_occ;
        n_step      = r_step;
        n_is_read   = r_is_read;
        n_key       = r_key;
        n_pos       = r_pos;
        n_pend_vld  = r_pend_vld;
        n_pend_pos  = r_pend_pos;
        n_pend_data = r_pend_data;
        n_valid     = 1'b0;
        n_status    = r_status;
        n_fpos      = r_fpos;
        n_odata     = r_odata;
        n_fill      = r_fill;
        n_last      = r_last;
        w_op        = lss_pkg::CELL_HOLD;

        unique case (r_state)
            lss_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_valid  = 1'b1;
                    n_status = lss_pkg::STAT_OK;
                    n_fpos   = '0;
                    n_odata  = '0;
                    n_last   = 1'b1;
                    n_key    = i_value;
                    n_pos    = i_position;
                    n_step   = '0;
                    n_pend_vld = 1'b0;
                    unique case (i_cmd)
                        lss_pkg::CMD_PUSH: begin
                            if (r_occ == lss_pkg::CNT_W'(lss_pkg::DEPTH)) begin
                                n_status = lss_pkg::STAT_FULL;
                            end else begin
                                w_op  = lss_pkg::CELL_SHIFT_DOWN;
                                n_occ = r_occ + lss_pkg::CNT_W'(1);
                            end
                        end
                        lss_pkg::CMD_POP: begin
                            if (r_occ == '0) begin
                                n_status = lss_pkg::STAT_EMPTY;
                            end else begin
                                w_op  = lss_pkg::CELL_SHIFT_UP;
                                n_occ = r_occ - lss_pkg::CNT_W'(1);
                            end
                        end
                        lss_pkg::CMD_CLEAR: begin
                            n_occ = '0;
                        end
                        lss_pkg::CMD_SEARCH: begin
                            n_valid   = 1'b0;
                            n_is_read = 1'b0;
                            n_state   = lss_pkg::ST_SCAN;
                        end
                        lss_pkg::CMD_READ: begin
                            if (i_position == '0 || i_position > lss_pkg::POS_W'(r_occ)) begin
                                n_status = lss_pkg::STAT_RANGE;
                            end else begin
                                n_valid   = 1'b0;
                                n_is_read = 1'b1;
                                n_state   = lss_pkg::ST_SCAN;
                            end
                        end
                        default: begin
                        end
                    endcase
                    n_fill = lss_pkg::POS_W'(n_occ);
                end
            end
            lss_pkg::ST_SCAN: begin
                w_op   = lss_pkg::CELL_SHIFT_UP;
                n_step = r_step + lss_pkg::STEP_W'(1);
                n_fill = lss_pkg::POS_W'(r_occ);
                if (r_is_read) begin
                    if (w_cur_pos == r_pos) begin
                        n_valid  = 1'b1;
                        n_status = lss_pkg::STAT_OK;
                        n_fpos   = w_cur_pos;
                        n_odata  = w_cell[0];
                        n_last   = 1'b1;
                    end
                end else if (lss_pkg::CNT_W'(r_step) < r_occ && w_cell[0] == r_key) begin
                    // hold each match back until the next one is found so the final one can carry last
                    if (r_pend_vld) begin
                        n_valid  = 1'b1;
                        n_status = lss_pkg::STAT_OK;
                        n_fpos   = r_pend_pos;
                        n_odata  = r_pend_data;
                        n_last   = 1'b0;
                    end
                    n_pend_vld  = 1'b1;
                    n_pend_pos  = w_cur_pos;
                    n_pend_data = w_cell[0];
                end
                if (r_step == lss_pkg::STEP_W'(lss_pkg::DEPTH - 1)) begin
                    n_state = r_is_read ? lss_pkg::ST_IDLE : lss_pkg::ST_FINISH;
                end
            end
            lss_pkg::ST_FINISH: begin
                n_valid = 1'b1;
                n_last  = 1'b1;
                n_fill  = lss_pkg::POS_W'(r_occ);
                if (r_pend_vld) begin
                    n_status = lss_pkg::STAT_OK;
                    n_fpos   = r_pend_pos;
                    n_odata  = r_pend_data;
                end else begin
                    n_status = lss_pkg::STAT_NOMATCH;
                    n_fpos   = '0;
                    n_odata  = '0;
                end
                n_pend_vld = 1'b0;
                n_state    = lss_pkg::ST_IDLE;
            end
            default: begin
                n_state = lss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lss_pkg::ST_IDLE;
            r_occ      <= '0;
            r_step     <= '0;
            r_pend_vld <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_occ      <= n_occ;
            r_step     <= n_step;
            r_pend_vld <= n_pend_vld;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_read   <= n_is_read;
        r_key       <= n_key;
        r_pos       <= n_pos;
        r_pend_pos  <= n_pend_pos;
        r_pend_data <= n_pend_data;
        r_status    <= n_status;
        r_fpos      <= n_fpos;
        r_odata     <= n_odata;
        r_fill      <= n_fill;
        r_last      <= n_last;
    end

    assign o_busy           = (r_state != lss_pkg::ST_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_found_position = r_fpos;
    assign o_data           = r_odata;
    assign o_fill_count     = r_fill;
    assign o_last           = r_last;

    `LSS_ASSERT_NOW(a_occ_bound, 1'b1, r_occ <= lss_pkg::CNT_W'(lss_pkg::DEPTH))
    `LSS_ASSERT_NEXT(a_occ_stable_scan, r_state == lss_pkg::ST_SCAN, $stable(r_occ))
    `LSS_ASSERT_NOW(a_nomatch_final,
        o_valid && o_status == lss_pkg::STAT_NOMATCH, o_last && o_found_position == '0)
    `LSS_ASSERT_NEXT(a_search_busy,
        i_start && !o_busy && i_cmd == lss_pkg::CMD_SEARCH, o_busy && !o_valid)

endmodule

// File: verif/lifo_stack_with_search_tb.sv
// self-checking testbench for the lifo stack with search: shadow stack and result checker
`timescale 1ns / 1ps

module lifo_stack_with_search_tb;

    // codes the block does not define; they must change nothing
    localparam logic [lss_pkg::CMD_W-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [lss_pkg::CMD_W-1:0] CMD_SPARE_7 = 3'd7;

    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_PRINTS  = 40;
    localparam int PHASES      = 11;
    localparam int PHASE_LEN   = 40;

    typedef struct {
        lss_pkg::t_status           status;
        logic [lss_pkg::POS_W-1:0]  found_pos;
        logic [lss_pkg::DATA_W-1:0] data;
        logic [lss_pkg::POS_W-1:0]  fill;
        logic                       last;
    } t_stack_result;

    // shadow copy of the stack plus the results still owed by the block
    class t_stack_shadow;
        logic [lss_pkg::DATA_W-1:0] words [lss_pkg::DEPTH];
        int                         held;
        t_stack_result              awaited [$];
        int                         mismatches;
        int                         prints;

        function new();
            held       = 0;
            mismatches = 0;
            prints     = 0;
        endfunction

        function logic [lss_pkg::DATA_W-1:0] word_from_top(int pos);
            return words[held - pos];
        endfunction

        // fill is taken after the command, so callers update held first
        function void owe_result(lss_pkg::t_status st, int pos,
                                 logic [lss_pkg::DATA_W-1:0] dat, bit fin);
            t_stack_result r;
            r.status    = st;
            r.found_pos = lss_pkg::POS_W'(pos);
            r.data      = dat;
            r.fill      = lss_pkg::POS_W'(held);
            r.last      = fin;
            awaited.push_back(r);
        endfunction

        function void note_request(logic [lss_pkg::CMD_W-1:0] cmd,
                                   logic [lss_pkg::DATA_W-1:0] value,
                                   logic [lss_pkg::POS_W-1:0] position);
            int hits;
            int seen;
            hits = 0;
            seen = 0;
            case (cmd)
                lss_pkg::CMD_PUSH: begin
                    if (held >= lss_pkg::DEPTH) begin
                        owe_result(lss_pkg::STAT_FULL, 0, '0, 1'b1);
                    end else begin
                        words[held] = value;
                        held++;
                        owe_result(lss_pkg::STAT_OK, 0, '0, 1'b1);
                    end
                end
                lss_pkg::CMD_POP: begin
                    if (held == 0) begin
                        owe_result(lss_pkg::STAT_EMPTY, 0, '0, 1'b1);
                    end else begin
                        held--;
                        owe_result(lss_pkg::STAT_OK, 0, '0, 1'b1);
                    end
                end
                lss_pkg::CMD_CLEAR: begin
                    held = 0;
                    owe_result(lss_pkg::STAT_OK, 0, '0, 1'b1);
                end
                lss_pkg::CMD_SEARCH: begin
                    for (int i = 1; i <= held; i++)
                        if (words[held - i] == value) hits++;
                    // matches come out top first, last flag on the final one
                    for (int i = 1; i <= held; i++) begin
                        if (words[held - i] == value) begin
                            seen++;
                            owe_result(lss_pkg::STAT_OK, i, words[held - i], seen == hits);
                        end
                    end
                    if (hits == 0) owe_result(lss_pkg::STAT_NOMATCH, 0, '0, 1'b1);
                end
                lss_pkg::CMD_READ: begin
                    if (position == 0 || position > held)
                        owe_result(lss_pkg::STAT_RANGE, 0, '0, 1'b1);
                    else
                        owe_result(lss_pkg::STAT_OK, position, words[held - position], 1'b1);
                end
                default: begin
                    owe_result(lss_pkg::STAT_OK, 0, '0, 1'b1);
                end
            endcase
        endfunction

        task log_mismatch(string msg);
            mismatches++;
            if (prints < MAX_PRINTS) begin
                $display("mismatch at %0t ns: %s", $time, msg);
                prints++;
            end
        endtask

        task check_result(logic [lss_pkg::STAT_W-1:0] st, logic [lss_pkg::POS_W-1:0] pos,
                          logic [lss_pkg::DATA_W-1:0] dat, logic [lss_pkg::POS_W-1:0] fill,
                          logic fin);
            t_stack_result want;
            if (awaited.size() == 0) begin
                log_mismatch($sformatf("unexpected result status %0d data %h", st, dat));
                return;
            end
            want = awaited.pop_front();
            if (st !== want.status)
                log_mismatch($sformatf("status got %0d want %0d", st, want.status));
            if (pos !== want.found_pos)
                log_mismatch($sformatf("found_position got %0d want %0d", pos, want.found_pos));
            if (dat !== want.data)
                log_mismatch($sformatf("data got %h want %h", dat, want.data));
            if (fill !== want.fill)
                log_mismatch($sformatf("fill_count got %0d want %0d", fill, want.fill));
            if (fin !== want.last)
                log_mismatch($sformatf("last got %b want %b", fin, want.last));
        endtask
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_start;
    logic [lss_pkg::CMD_W-1:0]    i_cmd;
    logic [lss_pkg::DATA_W-1:0]   i_value;
    logic [lss_pkg::POS_W-1:0]    i_position;
    logic                         o_busy;
    logic                         o_valid;
    logic [lss_pkg::STAT_W-1:0]   o_status;
    logic [lss_pkg::POS_W-1:0]    o_found_position;
    logic [lss_pkg::DATA_W-1:0]   o_data;
    logic [lss_pkg::POS_W-1:0]    o_fill_count;
    logic                         o_last;

    t_stack_shadow              shadow;
    bit                         idling_on;
    int                         cycle_count;
    logic [lss_pkg::DATA_W-1:0] key_pool [6] = '{32'h0000_0000, 32'hFFFF_FFFF,
                                                 32'hA5A5_A5A5, 32'h5A5A_5A5A,
                                                 32'h0000_0001, 32'h8000_0000};

    lifo_stack_with_search u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_start          (i_start),
        .i_cmd            (i_cmd),
        .i_value          (i_value),
        .i_position       (i_position),
        .o_busy           (o_busy),
        .o_valid          (o_valid),
        .o_status         (o_status),
        .o_found_position (o_found_position),
        .o_data           (o_data),
        .o_fill_count     (o_fill_count),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            shadow.check_result(o_status, o_found_position, o_data, o_fill_count, o_last);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idling_on || r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // a small pool keeps duplicates common so searches hit several entries
    function automatic logic [lss_pkg::DATA_W-1:0] pick_word();
        if ($urandom_range(0, 1) == 0) return key_pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    task automatic send_command(logic [lss_pkg::CMD_W-1:0] cmd,
                                logic [lss_pkg::DATA_W-1:0] value,
                                logic [lss_pkg::POS_W-1:0] position);
        int gap;
        @(negedge i_clk);
        i_start    <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= value;
        i_position <= position;
        do @(posedge i_clk); while (o_busy);
        shadow.note_request(cmd, value, position);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_start <= 1'b0;
            i_value <= $urandom;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // stop sending and wait for every owed result
    task automatic hold_off();
        @(negedge i_clk);
        i_start <= 1'b0;
        while (shadow.awaited.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_command(int push_pct, int pop_pct);
        int                         r;
        logic [lss_pkg::DATA_W-1:0] key;
        logic [lss_pkg::POS_W-1:0]  pos;
        r   = $urandom_range(0, 99);
        pos = lss_pkg::POS_W'($urandom_range(0, 31));
        if (r < push_pct) begin
            send_command(lss_pkg::CMD_PUSH, pick_word(), pos);
        end else if (r < push_pct + pop_pct) begin
            send_command(lss_pkg::CMD_POP, $urandom, pos);
        end else if (r < push_pct + pop_pct + 20) begin
            if (shadow.held > 0 && $urandom_range(0, 9) < 7)
                key = shadow.word_from_top($urandom_range(1, shadow.held));
            else
                key = pick_word();
            send_command(lss_pkg::CMD_SEARCH, key, pos);
        end else if (r < push_pct + pop_pct + 40) begin
            if (shadow.held > 0 && $urandom_range(0, 4) != 0)
                pos = lss_pkg::POS_W'($urandom_range(1, shadow.held));
            send_command(lss_pkg::CMD_READ, $urandom, pos);
        end else if (r < push_pct + pop_pct + 42) begin
            send_command(lss_pkg::CMD_CLEAR, $urandom, pos);
        end else begin
            send_command(lss_pkg::CMD_W'($urandom_range(CMD_SPARE_5, CMD_SPARE_7)),
                         $urandom, pos);
        end
    endtask

    initial begin
        shadow      = new();
        cycle_count = 0;
        idling_on   = 1'b1;
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_cmd       = lss_pkg::CMD_PUSH;
        i_value     = '0;
        i_position  = '0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_command(lss_pkg::CMD_POP, '0, '0);
        send_command(lss_pkg::CMD_SEARCH, '0, '0);
        repeat (lss_pkg::DEPTH) send_command(lss_pkg::CMD_PUSH, '1, 5'd31);
        send_command(lss_pkg::CMD_PUSH, '0, '0);
        // every entry matches, so the longest burst of results
        send_command(lss_pkg::CMD_SEARCH, '1, '0);
        send_command(lss_pkg::CMD_SEARCH, '0, '0);
        send_command(lss_pkg::CMD_READ, '0, 5'd0);
        send_command(lss_pkg::CMD_READ, '0, lss_pkg::POS_W'(lss_pkg::DEPTH));
        send_command(lss_pkg::CMD_READ, '0, lss_pkg::POS_W'(lss_pkg::DEPTH + 1));
        send_command(CMD_SPARE_5, '1, 5'd31);
        send_command(CMD_SPARE_7, '0, '0);
        send_command(lss_pkg::CMD_CLEAR, '1, '0);
        hold_off();

        // phases cycle through filling, mixed and draining traffic
        for (int phase = 0; phase < PHASES; phase++) begin
            idling_on = ($urandom_range(0, 3) != 0);
            repeat (PHASE_LEN) begin
                case (phase % 3)
                    0:       random_command(50, 8);
                    1:       random_command(30, 28);
                    default: random_command(12, 46);
                endcase
            end
            if (phase == PHASES / 2) hold_off();
        end

        hold_off();
        repeat (lss_pkg::DEPTH + 4) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.awaited.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
